// ----- design/ddo_pkg.sv -----
// Package: beat types, register codes, fixed-point constants and arctangent table.
`timescale 1ns / 1ps
package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS + 1);

	localparam logic [7:0] REG_DIST_PER_TICK  = 8'd0;
	localparam logic [7:0] REG_INV_WHEEL_BASE = 8'd1;

	localparam logic [31:0] DIST_PER_TICK_RST  = 32'd5262284;
	localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd197991;

	localparam logic signed [32:0] TURN_PER_RAD_Q32 = 33'sd683565276;
	localparam logic signed [32:0] US_PER_S         = 33'sd1000000;
	localparam logic signed [33:0] CORDIC_GAIN_Q30  = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
		logic        [31:0] time_stamp_us;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic        [31:0] heading_angle;
		logic signed [31:0] linear_speed;
		logic signed [31:0] angular_speed;
	} out_beat_t;

	function automatic logic [31:0] atan_bam(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051E;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			24: v = 32'h00000029;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000003;
			29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ----- design/ddo_mul.sv -----
// Shared registered 33x33 signed multiplier.
`timescale 1ns / 1ps
module ddo_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- design/ddo_cordic.sv -----
// Iterative CORDIC: one rotation step per cycle, sine and cosine in Q4.30.
`timescale 1ns / 1ps
module ddo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic        [31:0] angle,
	output logic               done,
	output logic signed [33:0] cos_val,
	output logic signed [33:0] sin_val
);

	logic                            busy_q;
	logic                            done_q;
	logic [ddo_pkg::CORDIC_CNT_W-1:0] cnt_q;
	logic [1:0]                      quad_q;
	logic signed [33:0]              x_q;
	logic signed [33:0]              y_q;
	logic signed [33:0]              z_q;
	logic [31:0]                     ang_rot;
	logic [1:0]                      quad;
	logic signed [33:0]              xs;
	logic signed [33:0]              ys;
	logic signed [33:0]              at;

	assign ang_rot = angle + 32'h20000000;
	assign quad    = ang_rot[31:30];
	assign xs      = x_q >>> cnt_q;
	assign ys      = y_q >>> cnt_q;
	assign at      = {2'b00, ddo_pkg::atan_bam(int'(cnt_q))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == ddo_pkg::CORDIC_CNT_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + ddo_pkg::CORDIC_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= quad;
			x_q    <= ddo_pkg::CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= 34'(signed'(angle - {quad, 30'd0}));
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

// ----- design/ddo_div.sv -----
// Restoring divider: signed 64-bit numerator over unsigned 32-bit time, saturated to 32 bits.
`timescale 1ns / 1ps
module ddo_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic        [31:0] den,
	output logic               done,
	output logic signed [31:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic signed [31:0] res_q;
	logic [32:0] rem_sh;
	logic        fits;
	logic [63:0] mag;

	assign rem_sh = {rem_q, quo_q[63]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign mag    = num[63] ? 64'(-num) : 64'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (den != 32'd0);
			done_q <= (den == 32'd0);
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63];
			den_q <= den;
			rem_q <= '0;
			quo_q <= mag;
			if (den == 32'd0) begin
				if (num[63])
					res_q <= 32'sh80000000;
				else if (num != 64'sd0)
					res_q <= 32'sh7FFFFFFF;
				else
					res_q <= '0;
			end
		end else if (busy_q) begin
			if (cnt_q != 7'd0) begin
				rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
				quo_q <= {quo_q[62:0], fits};
			end else if (neg_q) begin
				res_q <= (quo_q > 64'h80000000) ? 32'sh80000000 : 32'(-quo_q);
			end else begin
				res_q <= (quo_q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_q[31:0];
			end
		end
	end

	assign done = done_q;
	assign quot = res_q;

endmodule

// ----- design/differential_drive_odometry.sv -----
// Top level: differential-drive odometry sequencer around a shared multiplier.
// Sequence: multiplier steps with the 16-step CORDIC alongside, two divisions, one output step;
//   a zero time delta skips the division iterations.
// A beat is taken only while idle; in_stall is high from accept until the result registers.
// The first beat after reset only latches counts and time; it yields no result.
// Reset clears the pose, the latched counts and time, and restores register defaults.
`timescale 1ns / 1ps
module differential_drive_odometry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ddo_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ddo_pkg::out_beat_t out_data,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_L, ST_R, ST_D, ST_RAD, ST_TH1, ST_TH2, ST_LIN,
		ST_AH, ST_AL, ST_CW, ST_CX, ST_CY, ST_DL, ST_DA, ST_OUT
	} state_t;

	state_t state_q;

	logic [31:0] dpt_q;
	logic [23:0] iwb_q;
	logic [31:0] pose_x_q, pose_y_q, heading_q;
	logic [31:0] prev_l_q, prev_r_q, prev_t_q;
	logic        started_q;
	logic        out_valid_q;
	ddo_pkg::out_beat_t out_q;

	logic signed [31:0] dlc_q, drc_q;
	logic [31:0]        dt_q;
	logic signed [31:0] dl_q, d_q;
	logic signed [56:0] rad_q;
	logic [31:0]        th_q, dth_q;
	logic signed [63:0] lnum_q, ah_q, anum_q;
	logic [31:0]        xs_q, ys_q;
	logic signed [31:0] lin_q;
	logic signed [31:0] ang_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] p_q;
	logic signed [31:0] dist_sat;
	logic signed [32:0] diff;
	logic signed [32:0] dsum;
	logic               accept;
	logic               cordic_done;
	logic signed [33:0] cos_val, sin_val;
	logic               div_start;
	logic signed [63:0] div_num;
	logic               div_done;
	logic signed [31:0] div_quot;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		if ((&p_q[65:47]) || !(|p_q[65:47]))
			dist_sat = p_q[47:16];
		else
			dist_sat = p_q[65] ? 32'sh80000000 : 32'sh7FFFFFFF;
	end

	assign diff = {dist_sat[31], dist_sat} - {dl_q[31], dl_q};
	assign dsum = {dist_sat[31], dist_sat} + {dl_q[31], dl_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_L: begin
				mul_a = {dlc_q[31], dlc_q};
				mul_b = {1'b0, dpt_q};
			end
			ST_R: begin
				mul_a = {drc_q[31], drc_q};
				mul_b = {1'b0, dpt_q};
			end
			ST_D: begin
				mul_a = diff;
				mul_b = {9'd0, iwb_q};
			end
			ST_RAD: begin
				mul_a = {1'b0, {7{p_q[56]}}, p_q[56:32]};
				mul_b = ddo_pkg::TURN_PER_RAD_Q32;
			end
			ST_TH1: begin
				mul_a = {1'b0, rad_q[31:0]};
				mul_b = ddo_pkg::TURN_PER_RAD_Q32;
			end
			ST_TH2: begin
				mul_a = {d_q[31], d_q};
				mul_b = ddo_pkg::US_PER_S;
			end
			ST_LIN: begin
				mul_a = {{16{rad_q[56]}}, rad_q[56:40]};
				mul_b = ddo_pkg::US_PER_S;
			end
			ST_AH: begin
				mul_a = {9'd0, rad_q[39:16]};
				mul_b = ddo_pkg::US_PER_S;
			end
			ST_CW: begin
				mul_a = {d_q[31], d_q};
				mul_b = cos_val[32:0];
			end
			ST_CX: begin
				mul_a = {d_q[31], d_q};
				mul_b = sin_val[32:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = lnum_q;
		case (state_q)
			ST_CY: div_start = 1'b1;
			ST_DL: begin
				div_start = div_done;
				div_num   = anum_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	ddo_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	ddo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && started_q),
		.angle   (heading_q),
		.done    (cordic_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	ddo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dt_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dpt_q       <= ddo_pkg::DIST_PER_TICK_RST;
			iwb_q       <= ddo_pkg::INV_WHEEL_BASE_RST;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			prev_t_q    <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == ddo_pkg::REG_DIST_PER_TICK)
					dpt_q <= cfg_data;
				else if (cfg_index == ddo_pkg::REG_INV_WHEEL_BASE)
					iwb_q <= cfg_data[23:0];
			end
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_l_q  <= in_data.left_count;
						prev_r_q  <= in_data.right_count;
						prev_t_q  <= in_data.time_stamp_us;
						started_q <= 1'b1;
						if (started_q)
							state_q <= ST_L;
					end
				end
				ST_L:   state_q <= ST_R;
				ST_R:   state_q <= ST_D;
				ST_D:   state_q <= ST_RAD;
				ST_RAD: state_q <= ST_TH1;
				ST_TH1: state_q <= ST_TH2;
				ST_TH2: state_q <= ST_LIN;
				ST_LIN: state_q <= ST_AH;
				ST_AH:  state_q <= ST_AL;
				ST_AL:  state_q <= ST_CW;
				ST_CW: begin
					if (cordic_done)
						state_q <= ST_CX;
				end
				ST_CX:  state_q <= ST_CY;
				ST_CY:  state_q <= ST_DL;
				ST_DL: begin
					if (div_done)
						state_q <= ST_DA;
				end
				ST_DA: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						pose_x_q    <= pose_x_q + xs_q;
						pose_y_q    <= pose_y_q + ys_q;
						heading_q   <= heading_q + dth_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dlc_q <= in_data.left_count - prev_l_q;
				drc_q <= in_data.right_count - prev_r_q;
				dt_q  <= in_data.time_stamp_us - prev_t_q;
			end
			ST_R:   dl_q <= dist_sat;
			ST_D:   d_q  <= dsum[32:1];
			ST_RAD: rad_q <= p_q[56:0];
			ST_TH1: th_q <= p_q[31:0];
			ST_TH2: dth_q <= th_q + p_q[63:32];
			ST_LIN: lnum_q <= p_q[63:0];
			ST_AH:  ah_q <= p_q[63:0];
			ST_AL:  anum_q <= (ah_q <<< 24) + p_q[63:0];
			ST_CX:  xs_q <= p_q[61:30];
			ST_CY:  ys_q <= p_q[61:30];
			ST_DL: begin
				if (div_done)
					lin_q <= div_quot;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q.x_position    <= pose_x_q + xs_q;
					out_q.y_position    <= pose_y_q + ys_q;
					out_q.heading_angle <= heading_q + dth_q;
					out_q.linear_speed  <= lin_q;
					out_q.angular_speed <= ang_q;
				end
			end
			ST_DA: begin
				if (div_done)
					ang_q <= div_quot;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- test/differential_drive_odometry_tb.sv -----
// Testbench: differential-drive odometry checked beat by beat against a fixed-point pose predictor.
`timescale 1ns / 1ps
module differential_drive_odometry_tb;

	localparam int DRAIN_CYCLES = 400;
	localparam int IDLE_LIMIT   = 6000;
	localparam int ITEMS        = 1750;
	localparam logic [7:0] REG_UNUSED = 8'd7;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	ddo_pkg::in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	ddo_pkg::out_beat_t out_data;
	logic      cfg_wr_en;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	differential_drive_odometry u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [31:0] m_dist_per_tick, m_inv_base;
	logic [31:0] m_x, m_y, m_heading, m_prev_l, m_prev_r, m_prev_t;
	logic        m_started;
	ddo_pkg::out_beat_t expected_poses[$];

	int errors, samples_sent, poses_checked, idle_cycles, burst_left, stall_mode;
	logic [31:0] cur_l, cur_r, cur_t;

	logic [31:0] arctan_turns [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rate_of(longint num, logic [31:0] dt);
		if (dt == 32'd0) begin
			if (num > 0) return 64'sd2147483647;
			if (num < 0) return -64'sd2147483648;
			return 0;
		end
		return clamp32((num * 64'sd1000000) / longint'(dt));
	endfunction

	task automatic heading_sincos(input logic [31:0] ang, output longint c, output longint s);
		logic [31:0] shifted;
		logic [1:0]  q;
		longint      z, x, y, xs, ys;
		shifted = ang + 32'h20000000;
		q = shifted[31:30];
		z = longint'(int'(ang - {q, 30'b0}));
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(arctan_turns[i]);
			end else begin
				x += ys; y -= xs; z += longint'(arctan_turns[i]);
			end
		end
		case (q)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_pose(input ddo_pkg::in_beat_t b);
		longint dl, dr, d, rad, c, s;
		logic [63:0] ah, al, turn;
		logic [31:0] dtheta, dt;
		ddo_pkg::out_beat_t r;
		if (!m_started) begin
			m_started = 1'b1;
			m_prev_l = b.left_count;
			m_prev_r = b.right_count;
			m_prev_t = b.time_stamp_us;
			return;
		end
		dl = clamp32((longint'(int'(b.left_count - m_prev_l)) * longint'(m_dist_per_tick)) >>> 16);
		dr = clamp32((longint'(int'(b.right_count - m_prev_r)) * longint'(m_dist_per_tick)) >>> 16);
		d = (dl + dr) >>> 1;
		rad = (dr - dl) * longint'(m_inv_base);
		turn = 64'd683565276;
		ah = rad >>> 32;
		al = rad & 64'hFFFFFFFF;
		dtheta = 32'(ah * turn) + 32'((al * turn) >> 32);
		heading_sincos(m_heading, c, s);
		m_x += 32'((d * c) >>> 30);
		m_y += 32'((d * s) >>> 30);
		m_heading += dtheta;
		dt = b.time_stamp_us - m_prev_t;
		r.x_position    = m_x;
		r.y_position    = m_y;
		r.heading_angle = m_heading;
		r.linear_speed  = 32'(rate_of(d, dt));
		r.angular_speed = 32'(rate_of(rad >>> 16, dt));
		m_prev_l = b.left_count;
		m_prev_r = b.right_count;
		m_prev_t = b.time_stamp_us;
		expected_poses.push_back(r);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h (pose %0d)", what, got, want, poses_checked);
	endtask

	// input accept, output check and watchdog
	always @(posedge clk) begin
		ddo_pkg::out_beat_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_pose(in_data);
			if (out_valid && !out_stall) begin
				if (expected_poses.size() == 0) begin
					report("unexpected pose beat, x_position", out_data.x_position, 32'd0);
				end else begin
					e = expected_poses.pop_front();
					if (out_data.x_position !== e.x_position)
						report("x_position", out_data.x_position, e.x_position);
					if (out_data.y_position !== e.y_position)
						report("y_position", out_data.y_position, e.y_position);
					if (out_data.heading_angle !== e.heading_angle)
						report("heading_angle", out_data.heading_angle, e.heading_angle);
					if (out_data.linear_speed !== e.linear_speed)
						report("linear_speed", out_data.linear_speed, e.linear_speed);
					if (out_data.angular_speed !== e.angular_speed)
						report("angular_speed", out_data.angular_speed, e.angular_speed);
				end
				poses_checked++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", idle_cycles);
				$display("differential_drive_odometry regression: fail");
				$finish;
			end
		end
	end

	// receiver stall pattern: switch mode now and then
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc, input logic [31:0] ts);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= '{left_count: lc, right_count: rc, time_stamp_us: ts};
		do @(posedge clk); while (in_stall);
		samples_sent++;
		cur_l = lc;
		cur_r = rc;
		cur_t = ts;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == ddo_pkg::REG_DIST_PER_TICK) m_dist_per_tick = val;
		else if (idx == ddo_pkg::REG_INV_WHEEL_BASE) m_inv_base = {8'd0, val[23:0]};
		@(posedge clk);
	endtask

	function automatic logic [31:0] count_step();
		case ($urandom_range(0, 19))
			0: return $urandom;
			1: return 32'd0;
			2: return 32'h7FFFFFFF;
			3: return 32'h80000000;
			default: return 32'(int'($urandom_range(0, 6000)) - 3000);
		endcase
	endfunction

	function automatic logic [31:0] time_step();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'd1;
			default: return $urandom_range(500, 50000);
		endcase
	endfunction

	task automatic test_first_latch;
		send_sample($urandom, $urandom, $urandom);
		send_sample(cur_l + 32'd100, cur_r + 32'd100, cur_t + 32'd1000);
		send_sample(cur_l - 32'd50, cur_r + 32'd50, cur_t + 32'd2000);
	endtask

	task automatic test_zero_dt;
		send_sample(cur_l + 32'd300, cur_r + 32'd10, cur_t);
		send_sample(cur_l - 32'd300, cur_r - 32'd10, cur_t);
		send_sample(cur_l, cur_r, cur_t);
		send_sample(cur_l + 32'd5, cur_r - 32'd5, cur_t);
	endtask

	task automatic test_wraps;
		send_sample(32'h7FFFFFF0, 32'h80000010, 32'hFFFFFF00);
		send_sample(32'h80000010, 32'h7FFFFFF0, 32'h00000100);
		send_sample(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF);
		send_sample(32'h00000001, 32'hFFFFFFFE, 32'h00000000);
	endtask

	task automatic test_huge_distance;
		drain();
		write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'hFFFFFFFF);
		write_reg(ddo_pkg::REG_INV_WHEEL_BASE, 32'h00FFFFFF);
		send_sample(cur_l + 32'h7FFFFFFF, cur_r + 32'h80000000, cur_t + 32'd7);
		send_sample(cur_l + 32'h80000000, cur_r + 32'h7FFFFFFF, cur_t + 32'd1);
		send_sample(cur_l + 32'h7FFFFFFF, cur_r + 32'h7FFFFFFF, cur_t);
		send_sample(cur_l + 32'h80000000, cur_r + 32'h80000000, cur_t + 32'hFFFFFFFF);
		drain();
		write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'd0);
		write_reg(ddo_pkg::REG_INV_WHEEL_BASE, 32'd0);
		send_sample(cur_l + 32'd1000, cur_r - 32'd1000, cur_t + 32'd100);
		send_sample(cur_l + 32'h80000000, cur_r, cur_t);
		drain();
		write_reg(REG_UNUSED, $urandom);
		write_reg(ddo_pkg::REG_DIST_PER_TICK, ddo_pkg::DIST_PER_TICK_RST);
		write_reg(ddo_pkg::REG_INV_WHEEL_BASE, {8'd0, ddo_pkg::INV_WHEEL_BASE_RST});
		send_sample(cur_l + 32'd2000, cur_r + 32'd2500, cur_t + 32'd10000);
	endtask

	task automatic test_random_drive;
		int n;
		for (int phase = 0; phase < 7; phase++) begin
			drain();
			case (phase)
				0: ;
				1: begin write_reg(ddo_pkg::REG_DIST_PER_TICK, $urandom);
					write_reg(ddo_pkg::REG_INV_WHEEL_BASE, $urandom); end
				2: begin write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'hFFFFFFFF);
					write_reg(ddo_pkg::REG_INV_WHEEL_BASE, 32'h00FFFFFF); end
				3: begin write_reg(ddo_pkg::REG_DIST_PER_TICK, 32'd0);
					write_reg(ddo_pkg::REG_INV_WHEEL_BASE, $urandom); end
				4: begin write_reg(ddo_pkg::REG_DIST_PER_TICK, $urandom);
					write_reg(ddo_pkg::REG_INV_WHEEL_BASE, 32'd0); end
				5: begin write_reg(ddo_pkg::REG_DIST_PER_TICK, $urandom_range(1000000, 20000000));
					write_reg(ddo_pkg::REG_INV_WHEEL_BASE, $urandom_range(50000, 2000000)); end
				default: begin write_reg(ddo_pkg::REG_DIST_PER_TICK, ddo_pkg::DIST_PER_TICK_RST);
					write_reg(ddo_pkg::REG_INV_WHEEL_BASE, {8'd0, ddo_pkg::INV_WHEEL_BASE_RST}); end
			endcase
			n = ITEMS / 7;
			repeat (n) send_sample(cur_l + count_step(), cur_r + count_step(), cur_t + time_step());
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_stall <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		stall_mode = 0;
		errors = 0;
		samples_sent = 0;
		poses_checked = 0;
		idle_cycles = 0;
		burst_left = 0;
		cur_l = '0; cur_r = '0; cur_t = '0;
		m_dist_per_tick = ddo_pkg::DIST_PER_TICK_RST;
		m_inv_base = {8'd0, ddo_pkg::INV_WHEEL_BASE_RST};
		m_x = '0; m_y = '0; m_heading = '0;
		m_prev_l = '0; m_prev_r = '0; m_prev_t = '0;
		m_started = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_latch();
		test_zero_dt();
		test_wraps();
		test_huge_distance();
		test_random_drive();
		drain();

		$display("covered %0d encoder samples and %0d pose beats across seven register settings,",
			samples_sent, poses_checked);
		$display("including zero time deltas, count and time wraps and clamped wheel travel");
		if (errors == 0 && expected_poses.size() == 0) begin
			$display("differential_drive_odometry regression: pass");
		end else begin
			$display("%0d mismatches, %0d poses never arrived", errors, expected_poses.size());
			$display("differential_drive_odometry regression: fail");
		end
		$finish;
	end

endmodule
